// File: rtl/kpc_pkg.sv
// Package for the key press classifier: codes, reset values and shared types.
`default_nettype none

package kpc_pkg;

  // Event codes reported once per tick
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;
  localparam logic [1:0] EV_DOUBLE = 2'd3;

  // Configuration port geometry and register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_TICKS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_WINDOW  = 2'd2;

  // Register reset values
  localparam logic [7:0]  DEBOUNCE_TICKS_RESET = 8'd8;
  localparam logic [15:0] LONG_TICKS_RESET     = 16'd750;
  localparam logic [15:0] DOUBLE_WINDOW_RESET  = 16'd50;

  // Default width of the hold and window counters
  localparam int COUNTER_WIDTH_DEFAULT = 16;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] long_ticks;
    logic [15:0] double_window;
  } kpc_cfg_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       stable_pressed;
  } kpc_result_t;

endpackage

`default_nettype wire

// File: rtl/kpc_if.sv
// Channel interfaces: raw tick samples in, classified events out.
`default_nettype none

interface kpc_tick_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface kpc_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic       stable_pressed;

  modport source (output valid, output event_code, output stable_pressed, input ready);
  modport sink   (input valid, input event_code, input stable_pressed, output ready);
endinterface

`default_nettype wire

// File: rtl/key_press_classifier_core.sv
// Key press classifier: debounces an active-low button pin and reports press events.
//
// Usage: one transaction on the ticks channel carries one raw pin sample
// (pin_level, 0 = pressed). For each tick the block returns exactly one
// transaction on the events channel: event_code (0 none, 1 single, 2 long,
// 3 double) and stable_pressed, the debounced level after that tick.
// The result of an accepted tick is registered in the output stage.
// Throughput is one tick per cycle while ticks.ready is high: the state update
// is a single pass of counter compares between the state registers and the
// result register. A two-entry output stage (result register plus skid entry)
// lets a tick be accepted while the previous result still waits; ticks.ready
// drops only when both entries hold results the receiver has not taken.
// Reset (rst, synchronous) clears all debounce and classifier state, empties
// the output stage and loads debounce_ticks 8, long_ticks 750 and
// double_window 50. Configuration writes (cfg_write, cfg_index, cfg_data)
// take effect at the clock edge; write them only while the block is idle.
`default_nettype none

module key_press_classifier_core
  import kpc_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  kpc_tick_if.sink                    ticks,
  kpc_event_if.source                 events,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  kpc_cfg_t    cfg;
  kpc_result_t step_result;
  kpc_result_t main_result;
  kpc_result_t skid_result;
  logic        main_valid;
  logic        skid_valid;
  logic        tick_fire;
  logic        event_fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_TICKS_RESET;
      cfg.long_ticks     <= LONG_TICKS_RESET;
      cfg.double_window  <= DOUBLE_WINDOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS: cfg.debounce_ticks <= cfg_data[7:0];
        CFG_LONG_TICKS:     cfg.long_ticks     <= cfg_data;
        CFG_DOUBLE_WINDOW:  cfg.double_window  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ticks.ready = ~skid_valid;
  assign tick_fire   = ticks.valid & ticks.ready;
  assign event_fire  = main_valid & events.ready;

  kpc_engine #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (tick_fire),
    .pin_level (ticks.pin_level),
    .cfg       (cfg),
    .result    (step_result)
  );

  // Output stage: result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (event_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (tick_fire) begin
      if (!main_valid || event_fire) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (event_fire) begin
      main_valid <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (event_fire) main_result <= skid_result;
    end else if (tick_fire) begin
      if (!main_valid || event_fire) begin
        main_result <= step_result;
      end else begin
        skid_result <= step_result;
      end
    end
  end

  assign events.valid          = main_valid;
  assign events.event_code     = main_result.event_code;
  assign events.stable_pressed = main_result.stable_pressed;

  // Skid entry is only used behind a held result
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry filled with empty result register");

  // A stalled result stays valid
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    main_valid && !events.ready |=> main_valid)
    else $error("result dropped while stalled");

  // A tick accepted into a full result register fills the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    tick_fire && main_valid && !events.ready |=> skid_valid)
    else $error("tick lost while output stalled");

endmodule

`default_nettype wire

// File: rtl/kpc_engine.sv
// Debounce and press classification state, updated once per accepted tick.
`default_nettype none

module kpc_engine
  import kpc_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        pin_level,
  input  wire kpc_cfg_t    cfg,
  output kpc_result_t      result
);

  // Compare width covers both the counters and the 16-bit thresholds
  localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  logic                     candidate_level, candidate_level_next;
  logic                     stable_level, stable_level_next;
  logic [7:0]               settle_count, settle_count_next;
  logic                     press_pending, press_pending_next;
  logic                     release_pending, release_pending_next;
  logic                     hold_active, hold_active_next;
  logic [COUNTER_WIDTH-1:0] hold_count, hold_count_next;
  logic                     window_active, window_active_next;
  logic [COUNTER_WIDTH-1:0] window_count, window_count_next;
  logic                     ignore_release, ignore_release_next;
  logic [7:0]               settle_inc;
  logic                     sample;
  logic [1:0]               ev;

  assign sample = ~pin_level;

  // One tick of debounce, window timing, hold timing and edge handling
  always_comb begin
    candidate_level_next = candidate_level;
    stable_level_next    = stable_level;
    settle_count_next    = settle_count;
    press_pending_next   = press_pending;
    release_pending_next = release_pending;
    hold_active_next     = hold_active;
    hold_count_next      = hold_count;
    window_active_next   = window_active;
    window_count_next    = window_count;
    ignore_release_next  = ignore_release;
    ev                   = EV_NONE;
    settle_inc           = (settle_count != 8'hFF) ? settle_count + 8'd1 : settle_count;

    // debounce
    if (settle_count != 8'd0) begin
      if (sample == candidate_level) begin
        settle_count_next = settle_inc;
        if (settle_inc >= cfg.debounce_ticks) begin
          press_pending_next   = candidate_level & ~stable_level;
          release_pending_next = stable_level & ~candidate_level;
          stable_level_next    = candidate_level;
          settle_count_next    = 8'd0;
        end
      end else begin
        settle_count_next = 8'd0;
      end
    end else begin
      candidate_level_next = sample;
      if (sample != stable_level) settle_count_next = 8'd1;
    end

    // double window timing
    if (window_active_next) begin
      if (CMP_W'(window_count_next) < CMP_W'(cfg.double_window)) begin
        if (window_count_next != CNT_MAX) window_count_next = window_count_next + 1'b1;
      end else begin
        hold_active_next    = 1'b0;
        hold_count_next     = '0;
        window_active_next  = 1'b0;
        window_count_next   = '0;
        ignore_release_next = 1'b0;
        ev                  = EV_SINGLE;
      end
    end

    // long press timing
    if (hold_active_next && (CMP_W'(hold_count_next) < CMP_W'(cfg.long_ticks))) begin
      if (hold_count_next != CNT_MAX) hold_count_next = hold_count_next + 1'b1;
      if (CMP_W'(hold_count_next) >= CMP_W'(cfg.long_ticks)) begin
        hold_active_next    = 1'b0;
        hold_count_next     = '0;
        window_active_next  = 1'b0;
        window_count_next   = '0;
        ignore_release_next = 1'b0;
        ev                  = EV_LONG;
      end
    end

    // accepted edges
    if (press_pending_next) begin
      press_pending_next  = 1'b0;
      ignore_release_next = 1'b0;
      hold_active_next    = 1'b1;
      if (window_active_next &&
          (CMP_W'(window_count_next) < CMP_W'(cfg.double_window))) begin
        hold_active_next    = 1'b0;
        hold_count_next     = '0;
        window_active_next  = 1'b0;
        window_count_next   = '0;
        ignore_release_next = 1'b1;
        ev                  = EV_DOUBLE;
      end
    end else if (release_pending_next) begin
      release_pending_next = 1'b0;
      if (hold_active_next && (CMP_W'(hold_count_next) < CMP_W'(cfg.long_ticks)) &&
          !ignore_release_next) begin
        window_active_next = 1'b1;
        window_count_next  = '0;
      end
      hold_active_next = 1'b0;
      hold_count_next  = '0;
    end
  end

  assign result.event_code     = ev;
  assign result.stable_pressed = stable_level_next;

  // State registers advance on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_level <= 1'b0;
      stable_level    <= 1'b0;
      settle_count    <= 8'd0;
      press_pending   <= 1'b0;
      release_pending <= 1'b0;
      hold_active     <= 1'b0;
      hold_count      <= '0;
      window_active   <= 1'b0;
      window_count    <= '0;
      ignore_release  <= 1'b0;
    end else if (step) begin
      candidate_level <= candidate_level_next;
      stable_level    <= stable_level_next;
      settle_count    <= settle_count_next;
      press_pending   <= press_pending_next;
      release_pending <= release_pending_next;
      hold_active     <= hold_active_next;
      hold_count      <= hold_count_next;
      window_active   <= window_active_next;
      window_count    <= window_count_next;
      ignore_release  <= ignore_release_next;
    end
  end

  // A pending settle always targets a level different from the stable one
  a_settle_target: assert property (@(posedge clk) disable iff (rst)
    settle_count != 8'd0 |-> candidate_level != stable_level)
    else $error("settle count running toward the stable level");

  // The hold counter only runs while a hold is active
  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    hold_count != '0 |-> hold_active)
    else $error("hold count running with no hold");

  // A double press leaves the classifier idle and ignores the next release
  a_double_clears: assert property (@(posedge clk) disable iff (rst)
    step && ev == EV_DOUBLE |=> ignore_release && !hold_active && !window_active)
    else $error("double press did not clear the classifier");

  // Edge flags are consumed in the tick that raises them
  a_edges_consumed: assert property (@(posedge clk) disable iff (rst)
    !press_pending && !release_pending)
    else $error("edge flag survived its tick");

endmodule

`default_nettype wire

// File: verif/tb_key_press_classifier_core.sv
`timescale 1ns / 1ps
// Testbench for key_press_classifier_core: button gestures checked tick by tick against a predictor.
module tb_key_press_classifier_core;
  import kpc_pkg::*;

  localparam int CW = COUNTER_WIDTH_DEFAULT;
  localparam logic [CW-1:0] CNT_SAT = '1;
  localparam int unsigned STALL_LIMIT = 1000;

  // raw pin levels, active low
  localparam logic PIN_DOWN = 1'b0;
  localparam logic PIN_UP   = 1'b1;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  kpc_tick_if  tick_if();
  kpc_event_if event_if();

  key_press_classifier_core dut (
    .clk       (clk),
    .rst       (rst),
    .ticks     (tick_if),
    .events    (event_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register shadow
  logic [7:0]  debounce_cfg;
  logic [15:0] long_cfg;
  logic [15:0] window_cfg;

  // debounce and gesture state mirror
  logic          cand_lvl;
  logic          stable_lvl;
  logic [7:0]    settle_cnt;
  logic          press_seen;
  logic          release_seen;
  logic          hold_on;
  logic [CW-1:0] hold_cnt;
  logic          window_on;
  logic [CW-1:0] window_cnt;
  logic          skip_release;

  kpc_result_t expected_events[$];
  int unsigned mismatch_count;
  int unsigned sink_wait;
  int unsigned quiet_cycles;
  int unsigned ticks_sent;
  bit          idle_on;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void clear_gesture();
    hold_on      = 1'b0;
    hold_cnt     = '0;
    window_on    = 1'b0;
    window_cnt   = '0;
    skip_release = 1'b0;
  endfunction

  function automatic void reset_predictor();
    debounce_cfg = DEBOUNCE_TICKS_RESET;
    long_cfg     = LONG_TICKS_RESET;
    window_cfg   = DOUBLE_WINDOW_RESET;
    cand_lvl     = 1'b0;
    stable_lvl   = 1'b0;
    settle_cnt   = '0;
    press_seen   = 1'b0;
    release_seen = 1'b0;
    clear_gesture();
  endfunction

  // Advance the mirror by one tick and return the event it reports
  function automatic kpc_result_t classify_tick(input logic pin);
    kpc_result_t res;
    logic        sample;
    sample = ~pin;
    res.event_code = EV_NONE;

    // debounce
    if (settle_cnt != 0) begin
      if (sample == cand_lvl) begin
        if (settle_cnt < 8'd255) settle_cnt++;
        if (settle_cnt >= debounce_cfg) begin
          press_seen   = cand_lvl & ~stable_lvl;
          release_seen = stable_lvl & ~cand_lvl;
          stable_lvl   = cand_lvl;
          settle_cnt   = '0;
        end
      end else begin
        settle_cnt = '0;
      end
    end else begin
      cand_lvl = sample;
      if (cand_lvl != stable_lvl) settle_cnt = 8'd1;
    end

    // double window expiry
    if (window_on) begin
      if (window_cnt < window_cfg) begin
        if (window_cnt < CNT_SAT) window_cnt++;
      end else begin
        clear_gesture();
        res.event_code = EV_SINGLE;
      end
    end

    // long hold
    if (hold_on && hold_cnt < long_cfg) begin
      if (hold_cnt < CNT_SAT) hold_cnt++;
      if (hold_cnt >= long_cfg) begin
        clear_gesture();
        res.event_code = EV_LONG;
      end
    end

    // accepted edges
    if (press_seen) begin
      press_seen   = 1'b0;
      skip_release = 1'b0;
      hold_on      = 1'b1;
      if (window_on && window_cnt < window_cfg) begin
        clear_gesture();
        skip_release   = 1'b1;
        res.event_code = EV_DOUBLE;
      end
    end else if (release_seen) begin
      release_seen = 1'b0;
      if (hold_on && hold_cnt < long_cfg && !skip_release) begin
        window_on  = 1'b1;
        window_cnt = '0;
      end
      hold_on  = 1'b0;
      hold_cnt = '0;
    end

    res.stable_pressed = stable_lvl;
    return res;
  endfunction

  // Predict on each tick transaction, check each event transaction
  always @(posedge clk) begin
    kpc_result_t want;
    if (!rst) begin
      if (tick_if.valid && tick_if.ready)
        expected_events.push_back(classify_tick(tick_if.pin_level));
      if (event_if.valid && event_if.ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected transaction: event_code %0d stable_pressed %0d",
                 event_if.event_code, event_if.stable_pressed);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          if (event_if.event_code !== want.event_code) begin
            $error("event_code: expected %0d, actual %0d", want.event_code,
                   event_if.event_code);
            mismatch_count++;
          end
          if (event_if.stable_pressed !== want.stable_pressed) begin
            $error("stable_pressed: expected %0d, actual %0d", want.stable_pressed,
                   event_if.stable_pressed);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver: random stall after each transaction while idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      event_if.ready <= 1'b0;
      sink_wait = 0;
    end else if (event_if.valid && event_if.ready) begin
      sink_wait = idle_on ? $urandom_range(0, 7) : 0;
      event_if.ready <= (sink_wait == 0);
    end else if (sink_wait != 0) begin
      sink_wait--;
      event_if.ready <= (sink_wait == 0);
    end else begin
      event_if.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (tick_if.valid && tick_if.ready) || (event_if.valid && event_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_tick(input logic pin);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      tick_if.valid <= 1'b0;
      @(posedge clk);
    end
    tick_if.valid     <= 1'b1;
    tick_if.pin_level <= pin;
    do begin
      @(posedge clk);
    end while (!tick_if.ready);
    ticks_sent++;
  endtask

  task automatic hold_pin(input logic pin, input int unsigned n);
    repeat (n) send_tick(pin);
  endtask

  task automatic press_release(input int unsigned down, input int unsigned up);
    hold_pin(PIN_DOWN, down);
    hold_pin(PIN_UP, up);
  endtask

  // Stop sending and wait until every expected event has arrived
  task automatic settle();
    tick_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] deb, input logic [15:0] hold_limit,
                           input logic [15:0] win);
    settle();
    write_reg(CFG_DEBOUNCE_TICKS, {8'd0, deb});
    write_reg(CFG_LONG_TICKS, hold_limit);
    write_reg(CFG_DOUBLE_WINDOW, win);
    cfg_write    <= 1'b0;
    debounce_cfg = deb;
    long_cfg     = hold_limit;
    window_cfg   = win;
  endtask

  // Reset values: glitch, single, long
  task automatic test_default_settings();
    hold_pin(PIN_UP, 12);
    press_release(5, 12);
    press_release(20, 80);
    press_release(770, 20);
  endtask

  // Short settings: every event kind plus bouncy edges
  task automatic test_gesture_mix();
    configure(8'd3, 16'd30, 16'd10);
    press_release(8, 20);
    press_release(40, 10);
    press_release(5, 5);
    press_release(5, 20);
    // third press after a double starts a fresh gesture
    press_release(5, 5);
    press_release(5, 5);
    press_release(5, 20);
    // bouncing contact around both edges
    hold_pin(PIN_DOWN, 1);
    hold_pin(PIN_UP, 1);
    hold_pin(PIN_DOWN, 2);
    hold_pin(PIN_UP, 1);
    hold_pin(PIN_DOWN, 6);
    hold_pin(PIN_UP, 2);
    hold_pin(PIN_DOWN, 1);
    hold_pin(PIN_UP, 20);
    // second press just after the window has closed
    press_release(5, 12);
    press_release(5, 20);
  endtask

  task automatic test_debounce_limits();
    // zero acts like one
    configure(8'd0, 16'd30, 16'd10);
    press_release(4, 20);
    repeat (6) press_release(1, 1);
    hold_pin(PIN_UP, 20);
    configure(8'd1, 16'd30, 16'd10);
    press_release(4, 20);
    press_release(3, 3);
    press_release(3, 20);
    configure(8'd40, 16'd1000, 16'd0);
    press_release(45, 45);
  endtask

  // Zero long time: no long press and no window at all
  task automatic test_no_long_press();
    configure(8'd3, 16'd0, 16'd10);
    press_release(10, 20);
    press_release(45, 20);
    press_release(5, 5);
    press_release(5, 20);
  endtask

  // Zero window: single right after the short release
  task automatic test_no_window();
    configure(8'd3, 16'd30, 16'd0);
    press_release(6, 10);
    press_release(5, 4);
    press_release(5, 10);
  endtask

  task automatic test_one_tick_long();
    configure(8'd1, 16'd1, 16'd5);
    press_release(3, 5);
    press_release(1, 5);
    press_release(2, 5);
  endtask

  // Longer hold and window thresholds, sent back to back
  task automatic test_long_thresholds();
    idle_on = 1'b0;
    configure(8'd1, 16'd80, 16'd40);
    press_release(85, 3);
    press_release(3, 48);
    idle_on = 1'b1;
  endtask

  task automatic test_random_gestures();
    int unsigned phase_end;
    int unsigned down_len;
    int unsigned up_len;
    bit          bouncy;
    for (int phase = 0; phase < 4; phase++) begin
      configure(8'($urandom_range(0, 4)), 16'($urandom_range(0, 40)),
                16'($urandom_range(0, 20)));
      phase_end = ticks_sent + 25;
      while (ticks_sent < phase_end) begin
        idle_on = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 49) == 0) settle();
        if ($urandom_range(0, 9) < 7) begin
          // well-formed press with random lengths, sometimes bouncing
          down_len = $urandom_range(1, long_cfg + debounce_cfg + 8);
          up_len   = $urandom_range(1, window_cfg + debounce_cfg + 8);
          bouncy   = ($urandom_range(0, 2) == 0);
          if (bouncy) begin
            repeat ($urandom_range(1, 3)) begin
              send_tick(PIN_DOWN);
              send_tick(PIN_UP);
            end
          end
          hold_pin(PIN_DOWN, down_len);
          if (bouncy) begin
            repeat ($urandom_range(1, 3)) begin
              send_tick(PIN_UP);
              send_tick(PIN_DOWN);
            end
          end
          hold_pin(PIN_UP, up_len);
        end else begin
          // raw noise
          repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = CFG_DEBOUNCE_TICKS;
    cfg_data          = '0;
    tick_if.valid     = 1'b0;
    tick_if.pin_level = PIN_UP;
    idle_on           = 1'b1;
    mismatch_count    = 0;
    quiet_cycles      = 0;
    ticks_sent        = 0;
    reset_predictor();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_gesture_mix();
    test_debounce_limits();
    test_no_long_press();
    test_no_window();
    test_one_tick_long();
    test_long_thresholds();
    test_random_gestures();

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
